/* hw/rtl/btm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_pkg: shared types and constants of the byte tape machine executor
// Tape geometry, request, status and loop codes, and the result of a cell
// operation.
// ----------------------------------------------------------------------------
package btm_pkg;

   // Tape geometry
   localparam int TAPE_DEPTH = 1024;
   localparam int IDX_W      = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int CELL_W     = 8;
   localparam int OUT_IDX_W  = 10;
   localparam int WIDE_W     = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
   localparam logic [IDX_W-1:0]  TAPE_LAST = IDX_W'(TAPE_DEPTH - 1);
   localparam logic [CELL_W-1:0] CELL_MAX  = CELL_W'(255);

   // Request codes
   typedef enum logic [2:0] {
      REQ_LEFT  = 3'd0,
      REQ_RIGHT = 3'd1,
      REQ_INC   = 3'd2,
      REQ_DEC   = 3'd3,
      REQ_READ  = 3'd4,
      REQ_WRITE = 3'd5,
      REQ_BEGIN = 3'd6,
      REQ_END   = 3'd7
   } req_code_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_WRAP    = 3'd1,
      ST_HELD    = 3'd2,
      ST_AT_ZERO = 3'd3,
      ST_AT_END  = 3'd4
   } status_type;

   // Loop actions
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SKIP = 2'd1,
      ACT_BACK = 2'd2
   } loop_type;

   // Outcome of one operation on the cell under the head
   typedef struct packed {
      logic [CELL_W-1:0] value;
      status_type        status;
      loop_type          action;
   } cell_op_result_type;

endpackage

/* hw/rtl/btm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is enabled.
// ----------------------------------------------------------------------------
module btm_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/btm_cell_op.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btm_cell_op: operation on the cell under the head
// Computes the new cell value, status and loop action for increment,
// decrement, write and the loop tests; other requests leave the cell as is.
// ----------------------------------------------------------------------------
module btm_cell_op (
   input  btm_pkg::req_code_type              code,
   input  logic [btm_pkg::CELL_W-1:0]         cur_value,
   input  logic [btm_pkg::CELL_W-1:0]         write_value,
   output btm_pkg::cell_op_result_type        result
);

   // Decode the request against the current cell
   always_comb begin
      result.value  = cur_value;
      result.status = btm_pkg::ST_OK;
      result.action = btm_pkg::ACT_NONE;
      case (code)
         btm_pkg::REQ_INC: begin
            if (cur_value == btm_pkg::CELL_MAX) begin
               result.value  = '0;
               result.status = btm_pkg::ST_WRAP;
            end else begin
               result.value = cur_value + btm_pkg::CELL_W'(1);
            end
         end
         btm_pkg::REQ_DEC: begin
            if (cur_value == '0) begin
               result.status = btm_pkg::ST_HELD;
            end else begin
               result.value = cur_value - btm_pkg::CELL_W'(1);
            end
         end
         btm_pkg::REQ_WRITE: begin
            result.value = write_value;
         end
         btm_pkg::REQ_BEGIN: begin
            if (cur_value == '0) begin
               result.action = btm_pkg::ACT_SKIP;
            end
         end
         btm_pkg::REQ_END: begin
            if (cur_value != '0) begin
               result.action = btm_pkg::ACT_BACK;
            end
         end
         default: begin
            result.value = cur_value;
         end
      endcase
   end

endmodule

/* hw/rtl/byte_tape_machine_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_tape_machine_executor: tape machine instruction executor
// Executes one tape instruction per transfer against a tape of byte cells.
// ----------------------------------------------------------------------------
// The block takes one instruction every clock cycle and returns its result in
// the cycle after the transfer, so an instruction stream runs at one per
// cycle as long as the result side keeps up. The cell under the head and its
// two neighbors live in registers; every move writes the cell being left back
// to the tape RAM and, where the RAM holds it, fetches the next neighbor
// through the RAM's single read port, so each instruction is a
// read-modify-write on registers. A high-water mark of the head
// tells which cells the RAM really holds; cells beyond it read as zero, so
// the tape is usable right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module byte_tape_machine_executor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_cell_index,
   output logic [7:0]  rsp_cell_value,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_loop_action
);

   localparam int IDX_W  = btm_pkg::IDX_W;
   localparam int CELL_W = btm_pkg::CELL_W;
   localparam int WIDE_W = btm_pkg::WIDE_W;

   // Head state and cell registers
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  max_ff, max_in;
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [CELL_W-1:0] left_ff, left_in;
   logic [CELL_W-1:0] right_ff, right_in;
   logic              pend_left_ff, pend_left_in;
   logic              pend_right_ff, pend_right_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [9:0]        rsp_index_ff;
   logic [CELL_W-1:0] rsp_value_ff;
   btm_pkg::status_type rsp_status_ff, status_in;
   btm_pkg::loop_type   rsp_action_ff;

   // Datapath
   logic                        accept;
   btm_pkg::req_code_type       code;
   btm_pkg::cell_op_result_type op;
   logic                        move_left, move_right;
   logic                        left_refused, right_refused;
   logic [IDX_W:0]              head_plus2;
   logic                        left_rd_ok, right_rd_ok;
   logic [CELL_W-1:0]           eff_left, eff_right;
   logic [WIDE_W-1:0]           head_wide;

   // Tape RAM ports
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign code      = btm_pkg::req_code_type'(req_type);

   // Neighbor values: take RAM data in the cycle after a fetch
   assign eff_left  = pend_left_ff  ? ram_rd_data : left_ff;
   assign eff_right = pend_right_ff ? ram_rd_data : right_ff;

   // Move decode and refusals at the tape ends
   assign left_refused  = accept && (code == btm_pkg::REQ_LEFT) &&
                          (head_ff == btm_pkg::TAPE_LAST);
   assign right_refused = accept && (code == btm_pkg::REQ_RIGHT) && (head_ff == '0);
   assign move_left     = accept && (code == btm_pkg::REQ_LEFT) && !left_refused;
   assign move_right    = accept && (code == btm_pkg::REQ_RIGHT) && !right_refused;

   // Fetch the next neighbor only where the RAM holds a written cell
   assign head_plus2  = {1'b0, head_ff} + (IDX_W+1)'(2);
   assign left_rd_ok  = head_plus2 <= {1'b0, max_ff};
   assign right_rd_ok = head_ff > IDX_W'(1);

   assign ram_wr_en   = move_left || move_right;
   assign ram_rd_en   = (move_left && left_rd_ok) || (move_right && right_rd_ok);
   assign ram_rd_addr = move_left ? head_plus2[IDX_W-1:0] : (head_ff - IDX_W'(2));

   btm_cell_op u_cell_op (
      .code        (code),
      .cur_value   (cur_ff),
      .write_value (req_write_value),
      .result      (op)
   );

   btm_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (btm_pkg::TAPE_DEPTH)
   ) u_tape_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (cur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next head, cell and neighbor values
   always_comb begin
      head_in       = head_ff;
      max_in        = max_ff;
      cur_in        = accept ? op.value : cur_ff;
      left_in       = eff_left;
      right_in      = eff_right;
      pend_left_in  = 1'b0;
      pend_right_in = 1'b0;
      if (move_left) begin
         head_in      = head_ff + IDX_W'(1);
         cur_in       = eff_left;
         right_in     = cur_ff;
         left_in      = '0;
         pend_left_in = left_rd_ok;
         if (head_in > max_ff) begin
            max_in = head_in;
         end
      end else if (move_right) begin
         head_in       = head_ff - IDX_W'(1);
         cur_in        = eff_right;
         left_in       = cur_ff;
         right_in      = '0;
         pend_right_in = right_rd_ok;
      end
   end

   // Status: refused moves override the cell result
   always_comb begin
      if (left_refused) begin
         status_in = btm_pkg::ST_AT_END;
      end else if (right_refused) begin
         status_in = btm_pkg::ST_AT_ZERO;
      end else begin
         status_in = op.status;
      end
   end

   assign head_wide    = WIDE_W'(head_in);
   assign rsp_valid_in = accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         max_ff        <= '0;
         cur_ff        <= '0;
         left_ff       <= '0;
         right_ff      <= '0;
         pend_left_ff  <= 1'b0;
         pend_right_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         max_ff        <= max_in;
         cur_ff        <= cur_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         pend_left_ff  <= pend_left_in;
         pend_right_ff <= pend_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the result of each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_index_ff  <= head_wide[9:0];
         rsp_value_ff  <= cur_in;
         rsp_status_ff <= status_in;
         rsp_action_ff <= op.action;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_index  = rsp_index_ff;
   assign rsp_cell_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_loop_action = rsp_action_ff;

`ifndef SYNTH
   // At most one neighbor fetch is in flight
   a_one_fetch: assert property (@(posedge clock) disable iff (reset)
      !(pend_left_ff && pend_right_ff))
      else $error("both neighbor fetches pending");

   // The head never passes the high-water mark
   a_head_le_max: assert property (@(posedge clock) disable iff (reset)
      head_ff <= max_ff)
      else $error("head beyond high-water mark");

   // A fetch never targets the cell being written back
   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != head_ff))
      else $error("tape read and write collide");

   // A transfer always leaves a result waiting
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("result missing after transfer");

   // A left move advances the head by exactly one step
   a_move_step: assert property (@(posedge clock) disable iff (reset)
      move_left |=> (head_ff == $past(head_ff) + IDX_W'(1)))
      else $error("head did not advance on move");
`endif

endmodule
